// File: hw/rtl/mvom_pkg.sv
// Shared types and constants for the multi-voice oscillator mixer.
`timescale 1ns / 1ps

package mvom_pkg;

   localparam int INDEX_W  = 3;
   localparam int SHAPE_W  = 2;
   localparam int STEP_W   = 32;
   localparam int GAIN_W   = 16;
   localparam int SAMPLE_W = 22;

   localparam int MIX_MAX = 2097151;
   localparam int MIX_MIN = -2097152;

   // Angle of a quarter cycle in Q30.
   localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

   typedef enum logic {
      OP_TICK  = 1'b0,
      OP_WRITE = 1'b1
   } opcode_type;

   typedef enum logic [SHAPE_W-1:0] {
      SHAPE_SINE   = 2'd0,
      SHAPE_SAW    = 2'd1,
      SHAPE_SQUARE = 2'd2,
      SHAPE_SILENT = 2'd3
   } shape_type;

endpackage

// File: hw/rtl/mvom_if.sv
// Request and response channel interfaces of the oscillator mixer.
`timescale 1ns / 1ps

interface mvom_req_if;
   logic                             valid;
   logic                             ready;
   mvom_pkg::opcode_type             opcode;
   logic [mvom_pkg::INDEX_W-1:0]     voice_index;
   logic                             voice_enable;
   logic [mvom_pkg::SHAPE_W-1:0]     voice_shape;
   logic [mvom_pkg::STEP_W-1:0]      phase_step;
   logic [mvom_pkg::GAIN_W-1:0]      voice_gain;
   logic [mvom_pkg::STEP_W-1:0]      start_phase;

   modport source (
      output valid, opcode, voice_index, voice_enable, voice_shape,
             phase_step, voice_gain, start_phase,
      input  ready
   );
   modport sink (
      input  valid, opcode, voice_index, voice_enable, voice_shape,
             phase_step, voice_gain, start_phase,
      output ready
   );
endinterface

interface mvom_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [mvom_pkg::SAMPLE_W-1:0] mixed_sample;

   modport source (output valid, mixed_sample, input ready);
   modport sink (input valid, mixed_sample, output ready);
endinterface

// File: hw/rtl/multi_voice_oscillator_mixer.sv
// Oscillator bank top level: voice memories, per-voice pipeline and mixer.
//
//   channel   dir   payload                                          transfer
//   req_chan  in    opcode, voice_index, voice_enable, voice_shape,  valid & ready
//                   phase_step, voice_gain, start_phase
//   rsp_chan  out   mixed_sample                                     valid & ready
//
// A voice write is taken while idle and leaves the block ready. A tick reads one voice
// from the settings and phase memories per cycle, then three pipeline stages and a
// final saturation step. Reset clears control state and the per-slot valid bits at
// once; no memory clearing pass is needed. A finished sample waits in the output
// register while new requests are taken; a tick waits in its drain state only when the
// previous sample has not yet been taken.
`timescale 1ns / 1ps

module multi_voice_oscillator_mixer #(
   parameter int NUM_VOICES      = 8,
   parameter int SINE_TABLE_BITS = 10,
   parameter int PHASE_BITS      = 32
) (
   input logic        clock,
   input logic        reset,
   mvom_req_if.sink   req_chan,
   mvom_rsp_if.source rsp_chan
);

   localparam int IDX_W    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int QBITS    = SINE_TABLE_BITS - 2;
   localparam int AW       = QBITS + 1;
   localparam int WAVE_W   = 17;
   localparam int PROD_W   = 34;
   localparam int ACC_W    = 23 + $clog2(NUM_VOICES);
   localparam int SAMPLE_W = mvom_pkg::SAMPLE_W;
   localparam logic [AW-1:0] QUARTER = AW'(1) << QBITS;

   typedef struct packed {
      logic                            enable;
      mvom_pkg::shape_type             shape;
      logic [PHASE_BITS-1:0]           step;
      logic [mvom_pkg::GAIN_W-1:0]     gain;
   } voice_cfg_type;

   localparam int CFG_W = $bits(voice_cfg_type);

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_type;

   state_type                   state_ff, state_in;
   logic [IDX_W-1:0]            issue_idx_ff, issue_idx_in;
   logic                        issue_on_ff, issue_on_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0]  rsp_sample_ff, rsp_sample_in;
   logic [NUM_VOICES-1:0]       slot_vld_ff, slot_vld_in;

   logic                        s1_vld_ff, s1_vld_in;
   logic                        s1_last_ff, s1_last_in;
   logic [IDX_W-1:0]            s1_idx_ff, s1_idx_in;
   logic                        s1_slot_vld_ff, s1_slot_vld_in;

   logic                        s2_vld_ff, s2_vld_in;
   logic                        s2_last_ff, s2_last_in;
   logic                        s2_en_ff, s2_en_in;
   logic                        s2_sine_ff, s2_sine_in;
   logic                        s2_neg_ff, s2_neg_in;
   logic [mvom_pkg::GAIN_W-1:0] s2_gain_ff, s2_gain_in;
   logic signed [WAVE_W-1:0]    s2_wave_ff, s2_wave_in;

   logic                        s3_vld_ff, s3_vld_in;
   logic                        s3_last_ff, s3_last_in;
   logic                        s3_en_ff, s3_en_in;
   logic signed [PROD_W-1:0]    s3_prod_ff, s3_prod_in;

   logic signed [ACC_W-1:0]     acc_ff, acc_in;

   logic                        accept;
   logic                        write_hit;
   logic [IDX_W-1:0]            write_idx;
   logic [PHASE_BITS-1:0]       step_aligned;
   logic [PHASE_BITS-1:0]       start_aligned;
   voice_cfg_type               cfg_wr;
   logic [CFG_W-1:0]            cfg_rd_bits;
   voice_cfg_type               cfg_rd;
   logic [PHASE_BITS-1:0]       phase_rd;
   logic                        s1_upd;
   logic                        phase_wr_en;
   logic [IDX_W-1:0]            phase_wr_addr;
   logic [PHASE_BITS-1:0]       phase_wr_data;
   logic [SINE_TABLE_BITS-1:0]  sin_idx;
   logic [QBITS-1:0]            sin_j;
   logic [AW-1:0]               rom_addr;
   logic [15:0]                 rom_data;
   logic signed [WAVE_W-1:0]    s2_value;
   logic signed [PROD_W-1:0]    s3_round;
   logic signed [SAMPLE_W-1:0]  sat_sample;

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign accept             = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.mixed_sample = rsp_sample_ff;

   if (PHASE_BITS >= 32) begin : g_align_up
      assign step_aligned  = PHASE_BITS'(req_chan.phase_step) << (PHASE_BITS - 32);
      assign start_aligned = PHASE_BITS'(req_chan.start_phase) << (PHASE_BITS - 32);
   end else begin : g_align_down
      assign step_aligned  = req_chan.phase_step[31 -: PHASE_BITS];
      assign start_aligned = req_chan.start_phase[31 -: PHASE_BITS];
   end

   assign write_idx = IDX_W'(req_chan.voice_index);
   assign write_hit = accept && (req_chan.opcode == mvom_pkg::OP_WRITE)
                      && (int'(req_chan.voice_index) < NUM_VOICES);

   always_comb begin
      cfg_wr.enable = req_chan.voice_enable;
      cfg_wr.shape  = mvom_pkg::shape_type'(req_chan.voice_shape);
      cfg_wr.step   = step_aligned;
      cfg_wr.gain   = req_chan.voice_gain;
   end

   mvom_ram #(.WIDTH(CFG_W), .DEPTH(NUM_VOICES)) u_cfg_ram (
      .clock   (clock),
      .wr_en   (write_hit),
      .wr_addr (write_idx),
      .wr_data (cfg_wr),
      .rd_addr (issue_idx_ff),
      .rd_data (cfg_rd_bits)
   );

   assign cfg_rd = voice_cfg_type'(cfg_rd_bits);

   assign s1_upd        = s1_vld_ff && s1_slot_vld_ff && cfg_rd.enable;
   assign phase_wr_en   = write_hit || s1_upd;
   assign phase_wr_addr = write_hit ? write_idx : s1_idx_ff;
   assign phase_wr_data = write_hit ? start_aligned : (phase_rd + cfg_rd.step);

   mvom_ram #(.WIDTH(PHASE_BITS), .DEPTH(NUM_VOICES)) u_phase_ram (
      .clock   (clock),
      .wr_en   (phase_wr_en),
      .wr_addr (phase_wr_addr),
      .wr_data (phase_wr_data),
      .rd_addr (issue_idx_ff),
      .rd_data (phase_rd)
   );

   assign sin_idx  = phase_rd[PHASE_BITS-1 -: SINE_TABLE_BITS];
   assign sin_j    = sin_idx[QBITS-1:0];
   assign rom_addr = sin_idx[QBITS] ? (QUARTER - {1'b0, sin_j}) : {1'b0, sin_j};

   mvom_sine_rom #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sine_rom (
      .clock   (clock),
      .rd_addr (rom_addr),
      .rd_data (rom_data)
   );

   always_comb begin
      s1_vld_in      = (state_ff == ST_RUN) && issue_on_ff;
      s1_last_in     = (issue_idx_ff == IDX_W'(NUM_VOICES - 1));
      s1_idx_in      = issue_idx_ff;
      s1_slot_vld_in = slot_vld_ff[issue_idx_ff];

      s2_vld_in  = s1_vld_ff;
      s2_last_in = s1_last_ff;
      s2_en_in   = s1_upd;
      s2_sine_in = (cfg_rd.shape == mvom_pkg::SHAPE_SINE);
      s2_neg_in  = sin_idx[SINE_TABLE_BITS-1];
      s2_gain_in = cfg_rd.gain;
      case (cfg_rd.shape)
         mvom_pkg::SHAPE_SAW: begin
            s2_wave_in = $signed({2'b00, phase_rd[PHASE_BITS-1 -: 15]}) - WAVE_W'(16384);
         end
         mvom_pkg::SHAPE_SQUARE: begin
            if (!phase_rd[PHASE_BITS-1]) begin
               s2_wave_in = WAVE_W'(-32768);
            end else if (phase_rd[PHASE_BITS-2:0] == '0) begin
               s2_wave_in = '0;
            end else begin
               s2_wave_in = WAVE_W'(32768);
            end
         end
         default: s2_wave_in = '0;
      endcase

      s2_value = s2_neg_ff ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});
      if (!s2_sine_ff) begin
         s2_value = s2_wave_ff;
      end
      s3_vld_in  = s2_vld_ff;
      s3_last_in = s2_last_ff;
      s3_en_in   = s2_en_ff;
      s3_prod_in = s2_value * $signed({1'b0, s2_gain_ff});

      s3_round = (s3_prod_ff + PROD_W'(16384)) >>> 15;
      acc_in   = acc_ff;
      if (accept) begin
         acc_in = '0;
      end else if (s3_vld_ff && s3_en_ff) begin
         acc_in = acc_ff + ACC_W'(s3_round);
      end

      slot_vld_in = slot_vld_ff;
      if (write_hit) begin
         slot_vld_in[write_idx] = 1'b1;
      end
   end

   always_comb begin
      if (acc_ff > ACC_W'(mvom_pkg::MIX_MAX)) begin
         sat_sample = SAMPLE_W'(mvom_pkg::MIX_MAX);
      end else if (acc_ff < ACC_W'(mvom_pkg::MIX_MIN)) begin
         sat_sample = SAMPLE_W'(mvom_pkg::MIX_MIN);
      end else begin
         sat_sample = acc_ff[SAMPLE_W-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      issue_idx_in  = issue_idx_ff;
      issue_on_in   = issue_on_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_chan.opcode == mvom_pkg::OP_TICK)) begin
               state_in     = ST_RUN;
               issue_idx_in = '0;
               issue_on_in  = 1'b1;
            end
         end
         ST_RUN: begin
            if (issue_on_ff) begin
               issue_idx_in = issue_idx_ff + 1'b1;
               if (issue_idx_ff == IDX_W'(NUM_VOICES - 1)) begin
                  issue_on_in = 1'b0;
               end
            end
            if (s3_vld_ff && s3_last_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = sat_sample;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issue_idx_ff  <= '0;
         issue_on_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_sample_ff <= '0;
      end else begin
         state_ff      <= state_in;
         issue_idx_ff  <= issue_idx_in;
         issue_on_ff   <= issue_on_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_sample_ff <= rsp_sample_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_vld_ff <= '0;
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
         s3_vld_ff   <= 1'b0;
      end else begin
         slot_vld_ff <= slot_vld_in;
         s1_vld_ff   <= s1_vld_in;
         s2_vld_ff   <= s2_vld_in;
         s3_vld_ff   <= s3_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff     <= s1_last_in;
      s1_idx_ff      <= s1_idx_in;
      s1_slot_vld_ff <= s1_slot_vld_in;
      s2_last_ff     <= s2_last_in;
      s2_en_ff       <= s2_en_in;
      s2_sine_ff     <= s2_sine_in;
      s2_neg_ff      <= s2_neg_in;
      s2_gain_ff     <= s2_gain_in;
      s2_wave_ff     <= s2_wave_in;
      s3_last_ff     <= s3_last_in;
      s3_en_ff       <= s3_en_in;
      s3_prod_ff     <= s3_prod_in;
      acc_ff         <= acc_in;
   end

   // A new request never lands while the voice pipeline still writes back phases.
   a_no_accept_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |-> (!s1_vld_ff && !s2_vld_ff && !s3_vld_ff))
      else $error("request accepted while the voice pipeline is busy");

   // The pipeline has drained by the time the mix is saturated.
   a_drain_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (!s1_vld_ff && !s2_vld_ff && !s3_vld_ff && !issue_on_ff))
      else $error("voice pipeline not empty in the final cycle");

   // A tick starts a pass over the voices; a voice write leaves the block ready.
   a_tick_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_chan.opcode == mvom_pkg::OP_TICK)) |=>
         ((state_ff == ST_RUN) && issue_on_ff && (issue_idx_ff == '0)))
      else $error("tick did not start a voice pass");

   a_write_ready: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_chan.opcode == mvom_pkg::OP_WRITE)) |=> (state_ff == ST_IDLE))
      else $error("voice write left the block busy");

endmodule

// File: hw/rtl/mvom_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module mvom_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/mvom_sine_rom.sv
// Quarter-wave sine table with a registered read, built at elaboration.
`timescale 1ns / 1ps

module mvom_sine_rom #(
   parameter int SINE_TABLE_BITS = 10,
   localparam int QBITS = SINE_TABLE_BITS - 2,
   localparam int AW = QBITS + 1
) (
   input  logic          clock,
   input  logic [AW-1:0] rd_addr,
   output logic [15:0]   rd_data
);

   localparam int QSIZE = 1 << QBITS;

   // Taylor series to the fifteenth power in unsigned Q30, truncated at each step.
   function automatic logic [15:0] quarter_sine(input int unsigned j);
      logic [63:0] x;
      logic [63:0] sum;
      logic [63:0] term;
      logic [63:0] r;
      x = (64'(j) * 64'(mvom_pkg::HALF_PI_Q30)) >> QBITS;
      sum = x;
      term = x;
      for (int n = 1; n <= 7; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         case (n)
            1:       term = term / 64'd6;
            2:       term = term / 64'd20;
            3:       term = term / 64'd42;
            4:       term = term / 64'd72;
            5:       term = term / 64'd110;
            6:       term = term / 64'd156;
            default: term = term / 64'd210;
         endcase
         if ((n % 2) == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      r = (sum * 64'd32768 + (64'd1 << 29)) >> 30;
      if (r > 64'd32768) begin
         r = 64'd32768;
      end
      return r[15:0];
   endfunction

   logic [15:0] rom [QSIZE+1];
   logic [15:0] rd_data_ff;

   for (genvar g = 0; g <= QSIZE; g++) begin : g_rom
      assign rom[g] = quarter_sine(g);
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= rom[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: test/tb.sv
// Self-checking testbench for the multi-voice oscillator mixer.
`timescale 1ns / 1ps

module tb;

   localparam int NUM_VOICES  = 8;
   localparam int IDLE_PCT    = 31;
   localparam int CYCLE_LIMIT = 400000;
   localparam int INDEX_W     = mvom_pkg::INDEX_W;
   localparam int SHAPE_W     = mvom_pkg::SHAPE_W;
   localparam int STEP_W      = mvom_pkg::STEP_W;
   localparam int GAIN_W      = mvom_pkg::GAIN_W;
   localparam int SAMPLE_W    = mvom_pkg::SAMPLE_W;

   typedef struct {
      mvom_pkg::opcode_type opcode;
      logic [INDEX_W-1:0]   voice_index;
      logic                 voice_enable;
      mvom_pkg::shape_type  voice_shape;
      logic [STEP_W-1:0]    phase_step;
      logic [GAIN_W-1:0]    voice_gain;
      logic [STEP_W-1:0]    start_phase;
   } voice_req_type;

   logic clock;
   logic reset;

   mvom_req_if req_bus ();
   mvom_rsp_if rsp_bus ();

   multi_voice_oscillator_mixer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Predicted voice bank.
   logic                bank_enable [NUM_VOICES];
   mvom_pkg::shape_type bank_shape  [NUM_VOICES];
   logic [STEP_W-1:0]   bank_step   [NUM_VOICES];
   logic [GAIN_W-1:0]   bank_gain   [NUM_VOICES];
   logic [STEP_W-1:0]   bank_phase  [NUM_VOICES];

   logic signed [SAMPLE_W-1:0] pending_samples [$];

   bit sender_idles   = 1'b1;
   bit receiver_idles = 1'b1;
   int hold_cycles    = 0;
   int error_count    = 0;
   int ticks_sent     = 0;
   int writes_sent    = 0;
   int samples_checked = 0;
   int cycle_count    = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic longint sine_value(input logic [STEP_W-1:0] phase);
      logic [9:0]  idx;
      logic [63:0] j;
      logic [63:0] x;
      logic [63:0] sum;
      logic [63:0] term;
      logic [63:0] divisor;
      logic [63:0] r;
      int          n;
      idx = phase[31:22];
      j = {56'd0, idx[7:0]};
      if (idx[8]) begin
         j = 64'd256 - j;
      end
      x = (j * 64'd1686629713) >> 8;
      sum = x;
      term = x;
      for (n = 1; n <= 7; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         divisor = 64'((2 * n) * (2 * n + 1));
         term = term / divisor;
         if (n % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      r = (sum * 64'd32768 + 64'd536870912) >> 30;
      if (r > 64'd32768) begin
         r = 64'd32768;
      end
      return idx[9] ? -longint'(r) : longint'(r);
   endfunction

   function automatic longint wave_value(input mvom_pkg::shape_type shape,
                                         input logic [STEP_W-1:0] phase);
      case (shape)
         mvom_pkg::SHAPE_SINE: begin
            return sine_value(phase);
         end
         mvom_pkg::SHAPE_SAW: begin
            return longint'(phase[31:17]) - 64'sd16384;
         end
         mvom_pkg::SHAPE_SQUARE: begin
            if (phase < 32'h8000_0000) return -64'sd32768;
            return (phase == 32'h8000_0000) ? 64'sd0 : 64'sd32768;
         end
         default: begin
            return 64'sd0;
         end
      endcase
   endfunction

   // Updates the predicted bank and returns 1 when the request yields a sample.
   function automatic bit apply_request(input voice_req_type r,
                                        output logic signed [SAMPLE_W-1:0] sample);
      longint acc;
      longint scaled;
      int     v;
      acc = 0;
      sample = '0;
      if (r.opcode == mvom_pkg::OP_WRITE) begin
         bank_enable[r.voice_index] = r.voice_enable;
         bank_shape[r.voice_index]  = r.voice_shape;
         bank_step[r.voice_index]   = r.phase_step;
         bank_gain[r.voice_index]   = r.voice_gain;
         bank_phase[r.voice_index]  = r.start_phase;
         return 1'b0;
      end
      for (v = 0; v < NUM_VOICES; v++) begin
         if (bank_enable[v]) begin
            scaled = wave_value(bank_shape[v], bank_phase[v]) * longint'(bank_gain[v])
                     + 64'sd16384;
            acc += scaled >>> 15;
         end
      end
      for (v = 0; v < NUM_VOICES; v++) begin
         if (bank_enable[v]) begin
            bank_phase[v] = bank_phase[v] + bank_step[v];
         end
      end
      if (acc > mvom_pkg::MIX_MAX) acc = mvom_pkg::MIX_MAX;
      if (acc < mvom_pkg::MIX_MIN) acc = mvom_pkg::MIX_MIN;
      sample = acc[SAMPLE_W-1:0];
      return 1'b1;
   endfunction

   function automatic voice_req_type make_write(input int index, input bit enable,
                                                input mvom_pkg::shape_type shape,
                                                input logic [STEP_W-1:0] step,
                                                input logic [GAIN_W-1:0] gain,
                                                input logic [STEP_W-1:0] start);
      voice_req_type r;
      r.opcode       = mvom_pkg::OP_WRITE;
      r.voice_index  = index[INDEX_W-1:0];
      r.voice_enable = enable;
      r.voice_shape  = shape;
      r.phase_step   = step;
      r.voice_gain   = gain;
      r.start_phase  = start;
      return r;
   endfunction

   function automatic voice_req_type make_tick();
      voice_req_type r;
      r = make_write(0, 1'b0, mvom_pkg::SHAPE_SINE, '0, '0, '0);
      r.opcode = mvom_pkg::OP_TICK;
      return r;
   endfunction

   function automatic voice_req_type random_request(input int write_pct);
      voice_req_type r;
      r.opcode       = ($urandom_range(99) < write_pct) ? mvom_pkg::OP_WRITE
                                                       : mvom_pkg::OP_TICK;
      r.voice_index  = INDEX_W'($urandom_range(NUM_VOICES - 1));
      r.voice_enable = ($urandom_range(99) < 80);
      r.voice_shape  = mvom_pkg::shape_type'(SHAPE_W'($urandom_range(3)));
      case ($urandom_range(3))
         0: r.phase_step = STEP_W'($urandom_range(4095));
         1: r.phase_step = 32'hFFFF_FFFF - STEP_W'($urandom_range(4095));
         default: r.phase_step = $urandom;
      endcase
      case ($urandom_range(7))
         0: r.voice_gain = '0;
         1: r.voice_gain = '1;
         default: r.voice_gain = GAIN_W'($urandom);
      endcase
      r.start_phase = $urandom;
      return r;
   endfunction

   task automatic send_request(input voice_req_type r);
      logic signed [SAMPLE_W-1:0] sample;
      @(negedge clock);
      while (sender_idles && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.opcode       = r.opcode;
      req_bus.voice_index  = r.voice_index;
      req_bus.voice_enable = r.voice_enable;
      req_bus.voice_shape  = r.voice_shape;
      req_bus.phase_step   = r.phase_step;
      req_bus.voice_gain   = r.voice_gain;
      req_bus.start_phase  = r.start_phase;
      req_bus.valid        = 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      if (apply_request(r, sample)) begin
         pending_samples = {pending_samples, sample};
         ticks_sent++;
      end else begin
         writes_sent++;
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input logic signed [SAMPLE_W-1:0] got,
                                  input logic signed [SAMPLE_W-1:0] want);
      error_count++;
      $display("mismatch at cycle %0d: %s, got %0d, wanted %0d",
               cycle_count, what, got, want);
   endtask

   task automatic test_reset_silence();
      send_request(make_tick());
   endtask

   task automatic test_sine_quadrants();
      send_request(make_write(0, 1'b1, mvom_pkg::SHAPE_SINE, 32'h4000_0000, 16'h8000,
                              32'h4000_0000));
      repeat (4) send_request(make_tick());
   endtask

   task automatic test_square_and_saw();
      send_request(make_write(0, 1'b0, mvom_pkg::SHAPE_SILENT, '1, '1, '1));
      send_request(make_write(1, 1'b1, mvom_pkg::SHAPE_SQUARE, 32'd1, '1, 32'h8000_0000));
      repeat (2) send_request(make_tick());
      send_request(make_write(2, 1'b1, mvom_pkg::SHAPE_SAW, '1, '1, '1));
      send_request(make_tick());
      send_request(make_write(2, 1'b1, mvom_pkg::SHAPE_SAW, '0, '1, '0));
      send_request(make_tick());
   endtask

   task automatic test_silent_shape();
      send_request(make_write(3, 1'b1, mvom_pkg::SHAPE_SILENT, 32'h1234_5678, '1, '0));
      send_request(make_tick());
   endtask

   task automatic test_full_bank();
      int v;
      for (v = 0; v < NUM_VOICES; v++) begin
         send_request(make_write(v, 1'b1, mvom_pkg::SHAPE_SQUARE, '0, '1, '0));
      end
      send_request(make_tick());
   endtask

   task automatic test_random_traffic(input int count, input int write_pct);
      repeat (count) send_request(random_request(write_pct));
      wait_drained();
   endtask

   task automatic test_gapless_stretch();
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      test_random_traffic(300, 20);
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
   endtask

   // The receiver refuses samples for a long stretch while requests keep coming.
   task automatic test_output_hold_off();
      hold_cycles  = 300;
      sender_idles = 1'b0;
      test_random_traffic(30, 10);
      sender_idles = 1'b1;
   endtask

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_bus.ready = 1'b0;
            hold_cycles--;
         end else if (receiver_idles) begin
            rsp_bus.ready = ($urandom_range(99) >= IDLE_PCT);
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_samples.size() == 0) begin
            report_mismatch("sample transfer with none pending", rsp_bus.mixed_sample, '0);
         end else begin
            if (rsp_bus.mixed_sample !== pending_samples[0]) begin
               report_mismatch("mixed_sample", rsp_bus.mixed_sample, pending_samples[0]);
            end
            void'(pending_samples.pop_front());
            samples_checked++;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d samples pending", cycle_count,
               pending_samples.size());
      $display("status: fail");
      $finish;
   end

   initial begin
      int v;
      for (v = 0; v < NUM_VOICES; v++) begin
         bank_enable[v] = 1'b0;
         bank_shape[v]  = mvom_pkg::SHAPE_SINE;
         bank_step[v]   = '0;
         bank_gain[v]   = '0;
         bank_phase[v]  = '0;
      end
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.opcode       = mvom_pkg::OP_TICK;
      req_bus.voice_index  = '0;
      req_bus.voice_enable = 1'b0;
      req_bus.voice_shape  = mvom_pkg::SHAPE_SINE;
      req_bus.phase_step   = '0;
      req_bus.voice_gain   = '0;
      req_bus.start_phase  = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_silence();
      test_sine_quadrants();
      test_square_and_saw();
      test_silent_shape();
      test_full_bank();
      wait_drained();
      test_random_traffic(600, 25);
      test_gapless_stretch();
      test_output_hold_off();
      test_random_traffic(800, 35);
      repeat (40) @(posedge clock);

      $display("Sent %0d voice writes and %0d ticks; compared %0d mixed samples.",
               writes_sent, ticks_sent, samples_checked);
      $display("Covered waveform corners, a full bank, a gapless stretch and output hold-off.");
      if (error_count == 0 && pending_samples.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
